FILE: hw/rtl/ams_pkg.sv
// ----------------------------------------------------------------------------
// ams_pkg - shared definitions for the actuator matrix time slicer
// Matrix geometry, field widths, register map, sequencer states and the
// status record passed back by the iterative divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ams_pkg;

    // Matrix geometry: finger rows by direction columns, stored finger-major
    localparam int NUM_DIRECTIONS = 4;
    localparam int NUM_FINGERS    = 5;
    localparam int NUM_CELLS      = NUM_DIRECTIONS * NUM_FINGERS;

    // Field widths
    localparam int TIME_W  = 16;                       // total and dwell time
    localparam int COUNT_W = $clog2(NUM_CELLS + 1);    // set-cell count
    localparam int STEP_W  = $clog2(TIME_W);           // divider step counter

    // Configuration port
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = ADDR_W - 2;

    localparam logic [TIME_W-1:0] TOTAL_TIME_RESET = TIME_W'(1000);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_TOTAL_SWITCH_TIME = 1'b0,
        REG_INVERT_POLARITY   = 1'b1
    } reg_idx_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    // Divider status towards the sequencer
    typedef struct packed {
        logic              done;
        logic [TIME_W-1:0] quotient;
    } div_result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ams_in_if.sv
// ----------------------------------------------------------------------------
// ams_in_if - activation pattern channel
// Valid/ready channel carrying one 20-cell activation pattern per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ams_in_if;

    logic                            valid;
    logic                            ready;
    logic [ams_pkg::NUM_CELLS-1:0]   cell_pattern;

    modport source (output valid, output cell_pattern, input ready);
    modport sink   (input valid, input cell_pattern, output ready);

endinterface

`default_nettype wire

FILE: hw/rtl/ams_out_if.sv
// ----------------------------------------------------------------------------
// ams_out_if - drive state channel
// Valid/ready channel carrying one line drive state per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ams_out_if;

    logic                                 valid;
    logic                                 ready;
    logic [ams_pkg::NUM_DIRECTIONS-1:0]   direction_lines;
    logic [ams_pkg::NUM_FINGERS-1:0]      finger_lines;
    logic [ams_pkg::TIME_W-1:0]           dwell_time;
    logic                                 empty_pattern;
    logic                                 last_result;

    modport source (
        output valid, output direction_lines, output finger_lines,
        output dwell_time, output empty_pattern, output last_result,
        input  ready
    );
    modport sink (
        input  valid, input direction_lines, input finger_lines,
        input  dwell_time, input empty_pattern, input last_result,
        output ready
    );

endinterface

`default_nettype wire

FILE: hw/rtl/actuator_matrix_time_slicer.sv
// ----------------------------------------------------------------------------
// actuator_matrix_time_slicer - time-multiplexed finger/direction matrix drive
// Counts the set cells of a pattern, divides the total switching time by the
// count and emits one registered drive state per set cell, or one empty state.
// ----------------------------------------------------------------------------
// Sequencing: a non-empty pattern runs the 16 divider steps of the shared
//   restoring divider, then hands over to the emit state, which registers the
//   first result; an empty pattern goes straight to the emit state.
// Throughput: one result per cycle while the sink keeps up; a pattern holds
//   the block until its last result is loaded, and no new one is taken before.
// Reset: rst_n asynchronous, active low; total_switch_time returns to 1000,
//   invert_polarity to 0, the sequencer to idle and the output valid flag to 0.
`timescale 1ns / 1ps
`default_nettype none

module actuator_matrix_time_slicer (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    ams_in_if.sink                           cells,
    ams_out_if.source                        drive,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ams_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [ams_pkg::DATA_W-1:0]  pwdata,
    output logic      [ams_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);

    localparam int ND = ams_pkg::NUM_DIRECTIONS;
    localparam int NF = ams_pkg::NUM_FINGERS;
    localparam int NC = ams_pkg::NUM_CELLS;

    // Configuration registers
    logic [ams_pkg::TIME_W-1:0]   total_reg;
    logic                         invert_reg;
    ams_pkg::reg_idx_t            reg_idx;

    // Sequencer
    ams_pkg::state_t              state_reg, state_next;
    logic [NC-1:0]                mask_reg, mask_next;
    logic                         empty_reg, empty_next;
    logic                         div_start;
    logic                         load_out;
    logic                         out_free;
    logic [ams_pkg::COUNT_W-1:0]  cell_count;
    ams_pkg::div_result_t         div_res;

    // Cell selection
    logic [NC-1:0]                lowest;
    logic [NC-1:0]                mask_rest;
    logic                         is_last;
    logic [ND-1:0]                dir_hot;
    logic [NF-1:0]                fing_hot;
    logic [ND-1:0]                idle_dir;
    logic [NF-1:0]                idle_fing;

    // Output register
    logic                         out_valid_reg;
    logic [ND-1:0]                out_dir_reg;
    logic [NF-1:0]                out_fing_reg;
    logic [ams_pkg::TIME_W-1:0]   out_dwell_reg;
    logic                         out_empty_reg;
    logic                         out_last_reg;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_idx = ams_pkg::reg_idx_t'(paddr[ams_pkg::ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg  <= ams_pkg::TOTAL_TIME_RESET;
            invert_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (reg_idx)
                ams_pkg::REG_TOTAL_SWITCH_TIME: total_reg  <= pwdata[ams_pkg::TIME_W-1:0];
                ams_pkg::REG_INVERT_POLARITY:   invert_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read-back
    always_comb
    begin
        case (reg_idx)
            ams_pkg::REG_TOTAL_SWITCH_TIME:
                prdata = {{(ams_pkg::DATA_W - ams_pkg::TIME_W){1'b0}}, total_reg};
            ams_pkg::REG_INVERT_POLARITY:
                prdata = {{(ams_pkg::DATA_W - 1){1'b0}}, invert_reg};
            default:
                prdata = '0;
        endcase
    end

    // ---------------- shared divider ----------------
    assign cell_count = ams_pkg::COUNT_W'($countones(cells.cell_pattern));

    ams_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (total_reg),
        .divisor  (cell_count),
        .result   (div_res)
    );

    // ---------------- cell selection ----------------
    // Lowest set cell of the remaining mask gives scan order finger then direction
    always_comb
    begin
        lowest    = mask_reg & (~mask_reg + 1'b1);
        mask_rest = mask_reg & ~lowest;
        is_last   = empty_reg || (mask_rest == '0);
        for (int d = 0; d < ND; d++)
        begin
            dir_hot[d] = 1'b0;
            for (int f = 0; f < NF; f++)
                dir_hot[d] = dir_hot[d] | lowest[f*ND + d];
        end
        for (int f = 0; f < NF; f++)
            fing_hot[f] = |lowest[f*ND +: ND];
        idle_dir  = invert_reg ? '1 : '0;
        idle_fing = invert_reg ? '0 : '1;
    end

    // ---------------- sequencer ----------------
    assign out_free    = !out_valid_reg || drive.ready;
    assign cells.ready = (state_reg == ams_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ams_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        mask_reg  <= mask_next;
        empty_reg <= empty_next;
    end

    always_comb
    begin
        state_next = state_reg;
        mask_next  = mask_reg;
        empty_next = empty_reg;
        div_start  = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ams_pkg::ST_IDLE:
            begin
                if (cells.valid)
                begin
                    mask_next  = cells.cell_pattern;
                    empty_next = (cells.cell_pattern == '0);
                    if (cells.cell_pattern == '0)
                        state_next = ams_pkg::ST_EMIT;
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ams_pkg::ST_DIVIDE;
                    end
                end
            end
            ams_pkg::ST_DIVIDE:
            begin
                if (div_res.done)
                    state_next = ams_pkg::ST_EMIT;
            end
            ams_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    load_out  = 1'b1;
                    mask_next = mask_rest;
                    if (is_last)
                        state_next = ams_pkg::ST_IDLE;
                end
            end
            default:
                state_next = ams_pkg::ST_IDLE;
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (drive.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_dir_reg   <= idle_dir ^ (empty_reg ? '0 : dir_hot);
            out_fing_reg  <= idle_fing ^ (empty_reg ? '0 : fing_hot);
            out_dwell_reg <= empty_reg ? '0 : div_res.quotient;
            out_empty_reg <= empty_reg;
            out_last_reg  <= is_last;
        end
    end

    assign drive.valid           = out_valid_reg;
    assign drive.direction_lines = out_dir_reg;
    assign drive.finger_lines    = out_fing_reg;
    assign drive.dwell_time      = out_dwell_reg;
    assign drive.empty_pattern   = out_empty_reg;
    assign drive.last_result     = out_last_reg;

    // ---------------- assertions ----------------
    // A taken pattern closes the input until its results are scheduled
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cells.valid && cells.ready |=> !cells.ready)
        else $error("input ready straight after a pattern transaction");

    // Divider finishes only while the sequencer waits for it
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> state_reg == ams_pkg::ST_DIVIDE)
        else $error("divider done outside the divide state");

    // A drive state loaded from a non-empty scan has exactly one active line of each kind
    a_single_cell: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && !empty_reg |=> $onehot(drive.direction_lines ^ idle_dir)
                                   && $onehot(drive.finger_lines ^ idle_fing))
        else $error("drive state selects more or fewer than one cell");

    // The empty result is always the final one
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        drive.valid && drive.empty_pattern |-> drive.last_result)
        else $error("empty-pattern result not marked last");

endmodule

`default_nettype wire

FILE: hw/rtl/ams_divider.sv
// ----------------------------------------------------------------------------
// ams_divider - iterative restoring divider
// Divides the total time by the set-cell count, one quotient bit per cycle.
// The quotient stays valid after done until the next start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ams_divider (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [ams_pkg::TIME_W-1:0]  dividend,
    input  wire logic [ams_pkg::COUNT_W-1:0] divisor,
    output ams_pkg::div_result_t             result
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [ams_pkg::STEP_W-1:0]    step_reg;
    logic [ams_pkg::TIME_W-1:0]    quo_reg;
    logic [ams_pkg::COUNT_W-1:0]   rem_reg;
    logic [ams_pkg::COUNT_W-1:0]   div_reg;

    logic [ams_pkg::COUNT_W:0]     trial;
    logic [ams_pkg::COUNT_W:0]     diff;
    logic                          fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, quo_reg[ams_pkg::TIME_W-1]};
        diff  = trial - {1'b0, div_reg};
        fits  = (trial >= {1'b0, div_reg});
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == ams_pkg::STEP_W'(ams_pkg::TIME_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == ams_pkg::STEP_W'(ams_pkg::TIME_W - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    // Datapath; remainder stays below the divisor so it fits COUNT_W bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[ams_pkg::TIME_W-2:0], fits};
            rem_reg <= fits ? diff[ams_pkg::COUNT_W-1:0] : trial[ams_pkg::COUNT_W-1:0];
        end
    end

    assign result.done     = done_reg;
    assign result.quotient = quo_reg;

endmodule

`default_nettype wire

FILE: dv/tb_actuator_matrix_time_slicer.sv
// ----------------------------------------------------------------------------
// tb_actuator_matrix_time_slicer - self-checking bench for the matrix slicer
// Feeds activation patterns over the valid/ready input channel, predicts every
// drive state from a local model of the scan and checks each output
// transaction in order. The timing and polarity registers are rewritten over
// the APB port between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_actuator_matrix_time_slicer;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 50;
    localparam int HOLD_CYCLES    = 300;

    // One expected drive state
    typedef struct {
        logic [ams_pkg::NUM_DIRECTIONS-1:0] dir_lines;
        logic [ams_pkg::NUM_FINGERS-1:0]    fing_lines;
        logic [ams_pkg::TIME_W-1:0]         dwell;
        logic                               empty;
        logic                               last;
    } drive_state_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ams_pkg::ADDR_W-1:0] paddr;
    logic [ams_pkg::DATA_W-1:0] pwdata;
    logic [ams_pkg::DATA_W-1:0] prdata;
    logic pready;

    ams_in_if  cells_if ();
    ams_out_if drive_if ();

    actuator_matrix_time_slicer i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cells   (cells_if),
        .drive   (drive_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the registers
    logic [ams_pkg::TIME_W-1:0] shadow_total_time;
    logic                       shadow_invert;

    logic [ams_pkg::NUM_CELLS-1:0] pending_patterns[$];
    drive_state_t                  expected_states[$];

    int unsigned patterns_sent;
    int unsigned patterns_taken;
    int unsigned mismatch_count;
    bit          idling_enabled;
    bit          hold_request;

    // Clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Mismatch reporting
    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Gap length: mostly none or short, a few long
    function automatic int unsigned draw_gap();
        int unsigned r;
        if (!idling_enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Expected drive states for one pattern, scanned finger then direction
    task automatic predict_drive_states(input logic [ams_pkg::NUM_CELLS-1:0] pattern);
        int unsigned                        count;
        int unsigned                        seen;
        logic [ams_pkg::NUM_DIRECTIONS-1:0] idle_dir;
        logic [ams_pkg::NUM_FINGERS-1:0]    idle_fing;
        logic [ams_pkg::TIME_W-1:0]         dwell;
        drive_state_t                       st;
        count     = $countones(pattern);
        idle_dir  = shadow_invert ? '1 : '0;
        idle_fing = shadow_invert ? '0 : '1;
        seen      = 0;
        if (count == 0)
        begin
            st.dir_lines  = idle_dir;
            st.fing_lines = idle_fing;
            st.dwell      = '0;
            st.empty      = 1'b1;
            st.last       = 1'b1;
            expected_states.push_back(st);
        end
        else
        begin
            dwell = ams_pkg::TIME_W'(shadow_total_time / count);
            for (int f = 0; f < ams_pkg::NUM_FINGERS; f++)
            begin
                for (int d = 0; d < ams_pkg::NUM_DIRECTIONS; d++)
                begin
                    if (pattern[f*ams_pkg::NUM_DIRECTIONS + d])
                    begin
                        seen++;
                        st.dir_lines  = idle_dir ^ (ams_pkg::NUM_DIRECTIONS'(1) << d);
                        st.fing_lines = idle_fing ^ (ams_pkg::NUM_FINGERS'(1) << f);
                        st.dwell      = dwell;
                        st.empty      = 1'b0;
                        st.last       = (seen == count);
                        expected_states.push_back(st);
                    end
                end
            end
        end
    endtask

    // Random pattern: sparse, dense, uniform, occasionally empty
    function automatic logic [ams_pkg::NUM_CELLS-1:0] random_pattern();
        logic [ams_pkg::NUM_CELLS-1:0] p;
        int unsigned                   r;
        int unsigned                   n;
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            p = '0;
        end
        else if (r < 40)
        begin
            p = '0;
            n = $urandom_range(1, 3);
            repeat (n) p[$urandom_range(0, ams_pkg::NUM_CELLS-1)] = 1'b1;
        end
        else if (r < 55)
        begin
            p = '1;
            n = $urandom_range(0, 2);
            repeat (n) p[$urandom_range(0, ams_pkg::NUM_CELLS-1)] = 1'b0;
        end
        else
        begin
            p = ams_pkg::NUM_CELLS'($urandom);
        end
        return p;
    endfunction

    // APB register write: setup, access, release
    task automatic write_register(input ams_pkg::reg_idx_t idx,
                                  input logic [ams_pkg::DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ams_pkg::ADDR_W'(idx) << 2;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            ams_pkg::REG_TOTAL_SWITCH_TIME: shadow_total_time = value[ams_pkg::TIME_W-1:0];
            ams_pkg::REG_INVERT_POLARITY:   shadow_invert     = value[0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Wait until every pattern is taken and every drive state has come out
    task automatic wait_drained();
        do @(posedge clk);
        while (pending_patterns.size() != 0 || cells_if.valid || expected_states.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [ams_pkg::TIME_W-1:0] total, input logic inv,
                             input int unsigned n_items, input bit idle);
        write_register(ams_pkg::REG_TOTAL_SWITCH_TIME,
                       {16'($urandom_range(0, 65535)), total});
        write_register(ams_pkg::REG_INVERT_POLARITY, {31'($urandom), inv});
        idling_enabled = idle;
        repeat (n_items) pending_patterns.push_back(random_pattern());
        wait_drained();
    endtask

    // Input driver
    int unsigned in_gap_left;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            cells_if.valid <= 1'b0;
            in_gap_left = 0;
        end
        else if (!cells_if.valid || patterns_taken == patterns_sent)
        begin
            if (in_gap_left > 0)
            begin
                cells_if.valid <= 1'b0;
                in_gap_left--;
            end
            else if (pending_patterns.size() != 0)
            begin
                cells_if.valid        <= 1'b1;
                cells_if.cell_pattern <= pending_patterns.pop_front();
                patterns_sent++;
                in_gap_left = draw_gap();
            end
            else
            begin
                cells_if.valid <= 1'b0;
            end
        end
    end

    // Input acceptance and prediction
    always @(posedge clk)
    begin
        if (rst_n && cells_if.valid && cells_if.ready)
        begin
            predict_drive_states(cells_if.cell_pattern);
            patterns_taken++;
        end
    end

    // Output sink: random stalls plus one long hold-off on request
    int unsigned out_stall_left;
    int unsigned hold_left;
    bit          hold_served;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            drive_if.ready <= 1'b0;
        end
        else
        begin
            if (hold_request && !hold_served)
            begin
                hold_served = 1'b1;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                drive_if.ready <= 1'b0;
                hold_left--;
            end
            else if (out_stall_left > 0)
            begin
                drive_if.ready <= 1'b0;
                out_stall_left--;
            end
            else
            begin
                drive_if.ready <= 1'b1;
                if ($urandom_range(0, 99) < 20)
                    out_stall_left = draw_gap();
            end
        end
    end

    // Output monitor
    always @(posedge clk)
    begin
        drive_state_t want;
        if (rst_n && drive_if.valid && drive_if.ready)
        begin
            if (expected_states.size() == 0)
            begin
                report_mismatch($sformatf("unexpected drive state dir=%h fing=%h dwell=%0d",
                                          drive_if.direction_lines, drive_if.finger_lines,
                                          drive_if.dwell_time));
            end
            else
            begin
                want = expected_states.pop_front();
                if (drive_if.direction_lines !== want.dir_lines)
                    report_mismatch($sformatf("direction_lines got %h want %h",
                                              drive_if.direction_lines, want.dir_lines));
                if (drive_if.finger_lines !== want.fing_lines)
                    report_mismatch($sformatf("finger_lines got %h want %h",
                                              drive_if.finger_lines, want.fing_lines));
                if (drive_if.dwell_time !== want.dwell)
                    report_mismatch($sformatf("dwell_time got %0d want %0d",
                                              drive_if.dwell_time, want.dwell));
                if (drive_if.empty_pattern !== want.empty)
                    report_mismatch($sformatf("empty_pattern got %b want %b",
                                              drive_if.empty_pattern, want.empty));
                if (drive_if.last_result !== want.last)
                    report_mismatch($sformatf("last_result got %b want %b",
                                              drive_if.last_result, want.last));
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel
    int unsigned quiet_cycles;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cells_if.valid && cells_if.ready) || (drive_if.valid && drive_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[actuator_matrix_time_slicer] ERROR");
                $finish;
            end
        end
    end

    // Sequence of phases
    initial
    begin
        cells_if.valid        = 1'b0;
        cells_if.cell_pattern = '0;
        drive_if.ready        = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        shadow_total_time     = ams_pkg::TOTAL_TIME_RESET;
        shadow_invert         = 1'b0;
        patterns_sent         = 0;
        patterns_taken        = 0;
        mismatch_count        = 0;
        quiet_cycles          = 0;
        out_stall_left        = 0;
        hold_left             = 0;
        hold_served           = 1'b0;
        hold_request          = 1'b0;
        idling_enabled        = 1'b1;
        rst_n                 = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty, full, checkerboards and every single cell at reset values
        pending_patterns.push_back('0);
        pending_patterns.push_back('1);
        pending_patterns.push_back(ams_pkg::NUM_CELLS'(20'h55555));
        pending_patterns.push_back(ams_pkg::NUM_CELLS'(20'hAAAAA));
        for (int i = 0; i < ams_pkg::NUM_CELLS; i++)
            pending_patterns.push_back(ams_pkg::NUM_CELLS'(1) << i);
        wait_drained();

        // Random phases across register settings, extremes included
        run_phase(16'hFFFF, 1'b1, 50, 1'b0);
        run_phase(16'h0000, 1'b0, 40, 1'b1);
        hold_request = 1'b1;
        run_phase(16'h0001, 1'b1, 40, 1'b1);
        run_phase(16'd7, 1'b0, 40, 1'b1);
        run_phase(ams_pkg::TIME_W'($urandom), 1'($urandom), 80, 1'b1);

        if (mismatch_count == 0)
            $display("[actuator_matrix_time_slicer] OK");
        else
            $display("[actuator_matrix_time_slicer] ERROR");
        $finish;
    end

endmodule
